>>> sv/indexed_list_insert_remove_assert.svh
// assertion macros for the indexed list checker
// no dependencies; included by the checker file
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ILIR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ILIR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/ilir_pkg.sv
// shared types and constants for the indexed list block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ilir_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int OP_W       = 2;
   localparam int ST_W       = 2;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_BOUNDS = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [IDX_W-1:0]      index;
      logic [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_value;
      logic [ST_W-1:0]       status;
      logic [CNT_W-1:0]      count;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                  adv;
      logic                  load;
      logic                  shift_up;
      logic                  shift_down;
      logic                  read;
      logic [IDX_W-1:0]      pos;
      logic [DATA_WIDTH-1:0] value;
   } cmd_type;

endpackage

`default_nettype wire

>>> sv/ilir_cell.sv
// one storage cell of the list chain: holds one entry, shifts with neighbors
// depends on ilir_pkg
`timescale 1ns / 1ps
`default_nettype none

module ilir_cell
   import ilir_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [IDX_W-1:0]      my_index,
   input  wire cmd_type               cmd,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   output logic [DATA_WIDTH-1:0]      data,
   output logic [DATA_WIDTH-1:0]      rd
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;
   logic                  hit, above;

   assign hit   = (cmd.pos == my_index);
   assign above = (my_index > cmd.pos);

   always_comb begin
      data_in = data_ff;
      if (cmd.load && hit) begin
         data_in = cmd.value;
      end else if (cmd.shift_up && above) begin
         data_in = left_data;
      end else if (cmd.shift_down && (above || hit)) begin
         data_in = right_data;
      end
   end

   // gated read, or-combined across the chain
   assign rd_in = (cmd.read && hit) ? data_ff : '0;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (cmd.adv) begin
         rd_ff <= rd_in;
      end
   end

   assign data = data_ff;
   assign rd   = rd_ff;

endmodule

`default_nettype wire

>>> sv/ilir_chain.sv
// row of list cells with neighbor links and the read-word or-combine
// depends on ilir_pkg and ilir_cell
`timescale 1ns / 1ps
`default_nettype none

module ilir_chain
   import ilir_pkg::*;
(
   input  wire logic             clock,
   input  wire cmd_type          cmd,
   output logic [DATA_WIDTH-1:0] rd_word
);

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_data[g+1];
      end
      ilir_cell u_cell (
         .clock      (clock),
         .my_index   (IDX_W'(g)),
         .cmd        (cmd),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[g]),
         .rd         (cell_rd[g])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end

endmodule

`default_nettype wire

>>> sv/indexed_list_insert_remove.sv
// indexed list: append, get, insert, remove on a 64-entry shifting cell chain
// one word per cycle sustained while the response side does not stall,
// since every cell shifts in parallel in the accepting cycle; the get
// read is registered in the cells and or-combined in the cycle after
// reset clears the count and the pipeline valids; entry contents are not
// cleared and are never read before being written
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_remove
   import ilir_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic              advance, accept;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              s1_valid_ff;
   logic [ST_W-1:0]   s1_status_ff, status_in;
   logic [CNT_W-1:0]  s1_count_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   cmd_type           cmd;
   logic [DATA_WIDTH-1:0] rd_word;
   logic [CNT_W-1:0]  idx_ext;
   logic              full;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   assign idx_ext = CNT_W'(req_data.index);
   assign full    = (count_ff >= CAP_COUNT);

   always_comb begin
      cmd            = '0;
      cmd.adv        = advance;
      cmd.value      = req_data.value;
      cmd.pos        = req_data.index;
      status_in      = ST_OK;
      count_in       = count_ff;
      unique case (req_data.op)
         OP_APPEND: begin
            cmd.pos = count_ff[IDX_W-1:0];
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.load = accept;
               count_in = count_ff + 1'b1;
            end
         end
         OP_GET: begin
            if (idx_ext >= count_ff) begin
               status_in = ST_BOUNDS;
            end else begin
               cmd.read = accept;
            end
         end
         OP_INSERT: begin
            if (idx_ext > count_ff) begin
               status_in = ST_BOUNDS;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.load     = accept;
               cmd.shift_up = accept;
               count_in     = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (idx_ext >= count_ff) begin
               status_in = ST_BOUNDS;
            end else begin
               cmd.shift_down = accept;
               count_in       = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   ilir_chain u_chain (
      .clock   (clock),
      .cmd     (cmd),
      .rd_word (rd_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (advance) begin
            s1_valid_ff  <= req_valid;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_status_ff      <= status_in;
         s1_count_ff       <= count_in;
         rsp_ff.read_value <= rd_word;
         rsp_ff.status     <= s1_status_ff;
         rsp_ff.count      <= s1_count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> sv/ilir_checker.sv
// port-level checker for the indexed list, bound to the top level
// depends on ilir_pkg and indexed_list_insert_remove_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_insert_remove_assert.svh"

module ilir_checker
   import ilir_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data
);

   logic unused_req;
   assign unused_req = req_valid ^ req_stall ^ (^req_data);

   `ILIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ILIR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   `ILIR_ASSERT_NOW(a_count_cap, clock, reset, rsp_valid, rsp_data.count <= CAP_COUNT)
   `ILIR_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && rsp_data.status == ST_FULL, rsp_data.count == CAP_COUNT)
   `ILIR_ASSERT_NOW(a_read_zero, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.read_value == '0)

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
